@@ src/vdrp_pkg.sv @@
package vdrp_pkg;

    localparam int VDRP_RAM_DEPTH = 262144;
    localparam int PTR_W          = 18;
    localparam int OFF_W          = 20;
    localparam int DATA_W         = 16;
    localparam int NUM_SETTINGS   = 18;
    localparam int SLOT_W         = 5;
    localparam int STATUS_SLOT    = 16;

    localparam logic [OFF_W-1:0] OFF_CTRL   = 20'h00000;
    localparam logic [OFF_W-1:0] OFF_WINX   = 20'h00002;
    localparam logic [OFF_W-1:0] OFF_PTR    = 20'h00030;
    localparam logic [OFF_W-1:0] OFF_STATUS = 20'h00034;
    localparam logic [OFF_W-1:0] OFF_RAM    = 20'h00036;
    localparam logic [OFF_W-1:0] OFF_AUX_LO = 20'h80000;
    localparam logic [OFF_W-1:0] OFF_AUX_HI = 20'h80008;

    // setting register offsets, slot 0 in the low element
    localparam logic [NUM_SETTINGS-1:0][OFF_W-1:0] SETTING_OFFS = {
        20'h0003e, OFF_STATUS, 20'h00032, 20'h00022, 20'h00020, 20'h0001e,
        20'h0001c, 20'h0001a, 20'h00018, 20'h00014, 20'h00012, 20'h00010,
        20'h0000e, 20'h0000c, 20'h0000a, 20'h00008, 20'h00006, 20'h00004
    };

    localparam logic [DATA_W-1:0] CTRL_CLR_MASK = 16'h0010;
    localparam logic [DATA_W-1:0] CTRL_SET_MASK = 16'h2100;
    localparam logic [DATA_W-1:0] STATUS_READ   = 16'h0001;

    typedef struct packed {
        logic              ctrl;
        logic              winx;
        logic              ptr;
        logic              ram;
        logic              aux_lo;
        logic              aux_hi;
        logic              status;
        logic              setting;
        logic [SLOT_W-1:0] slot;
    } t_dec;

endpackage

@@ src/vdrp_decode.sv @@
module vdrp_decode (
    input  logic [vdrp_pkg::OFF_W-1:0] i_offset,
    output vdrp_pkg::t_dec             o_dec
);
    import vdrp_pkg::*;

    always_comb begin
        o_dec         = '0;
        o_dec.ctrl    = (i_offset == OFF_CTRL);
        o_dec.winx    = (i_offset == OFF_WINX);
        o_dec.ptr     = (i_offset == OFF_PTR);
        o_dec.ram     = (i_offset == OFF_RAM);
        o_dec.aux_lo  = (i_offset == OFF_AUX_LO);
        o_dec.aux_hi  = (i_offset == OFF_AUX_HI);
        o_dec.status  = (i_offset == OFF_STATUS);
        for (int k = 0; k < NUM_SETTINGS; k++) begin
            if (i_offset == SETTING_OFFS[k]) begin
                o_dec.setting = 1'b1;
                o_dec.slot    = SLOT_W'(k);
            end
        end
    end

endmodule

@@ src/video_decoder_register_port_core.sv @@
// Register port of a video decoder card.
// The result passes the stage-1 register and then the output register.
// Throughput: one item per cycle while i_out_ready does not stall the output;
// the single-port synchronous frame RAM registers its read data in stage 1.
// Reset: clears registers, pointer and pipeline valids; status setting resets to 1;
// input not ready during reset. The frame RAM holds undefined data until written.
module video_decoder_register_port_core #(
    parameter int RAM_DEPTH = vdrp_pkg::VDRP_RAM_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_command,
    input  logic [vdrp_pkg::OFF_W-1:0]  i_offset,
    input  logic [vdrp_pkg::DATA_W-1:0] i_write_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [vdrp_pkg::DATA_W-1:0] o_read_data,
    output logic                        o_bad_write
);
    import vdrp_pkg::*;

    localparam int IW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int HI_W  = PTR_W - 10;
    localparam int TBL_N = 1 << HI_W;

    t_dec w_dec;

    logic [DATA_W-1:0] r_ctrl;
    logic [DATA_W-1:0] r_winx;
    logic [DATA_W-1:0] r_aux_lo;
    logic [DATA_W-1:0] r_aux_hi;
    logic [DATA_W-1:0] r_setting [NUM_SETTINGS];
    logic [PTR_W-1:0]  r_ptr;
    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     n_idx;
    logic [PTR_W-1:0]  n_ptr;

    logic [DATA_W-1:0] r_mem [RAM_DEPTH];
    logic [DATA_W-1:0] r_ram_q;

    logic              r_s1_valid;
    logic              r_s1_ram;
    logic              r_s1_bad;
    logic [DATA_W-1:0] r_s1_rd;
    logic [DATA_W-1:0] n_s1_rd;
    logic              n_s1_bad;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_rd;
    logic              r_out_bad;

    logic w_accept;
    logic w_s1_adv;
    logic w_wr;
    logic w_rd;

    logic [IW-1:0]    c_tbl [TBL_N];
    logic [PTR_W-1:0] w_load;
    logic [IW:0]      w_sum;
    logic [IW-1:0]    w_load_idx;

    vdrp_decode u_decode (
        .i_offset (i_offset),
        .o_dec    (w_dec)
    );

    for (genvar g = 0; g < TBL_N; g++) begin : g_tbl
        assign c_tbl[g] = IW'((g * 1024) % RAM_DEPTH);
    end

    assign w_s1_adv   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = i_rst_n && (!r_s1_valid || w_s1_adv);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_wr       = w_accept && i_command;
    assign w_rd       = w_accept && !i_command;

    assign w_load     = {i_write_data, 2'b00};
    assign w_sum      = {1'b0, c_tbl[w_load[PTR_W-1:10]]} + (IW+1)'(w_load[9:0]);
    assign w_load_idx = (w_sum >= (IW+1)'(RAM_DEPTH)) ? IW'(w_sum - (IW+1)'(RAM_DEPTH))
                                                       : IW'(w_sum);

    always_comb begin
        n_ptr = r_ptr;
        n_idx = r_idx;
        if (w_accept && w_dec.ram) begin
            n_ptr = r_ptr + 1'b1;
            if (r_ptr == {PTR_W{1'b1}} || r_idx == IW'(RAM_DEPTH - 1)) begin
                n_idx = '0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end else if (w_wr && w_dec.ptr) begin
            n_ptr = w_load;
            n_idx = w_load_idx;
        end
    end

    always_comb begin
        n_s1_rd  = '0;
        n_s1_bad = 1'b0;
        if (i_command) begin
            n_s1_bad = !(w_dec.ctrl || w_dec.winx || w_dec.ptr || w_dec.ram ||
                         w_dec.aux_lo || w_dec.aux_hi || w_dec.setting);
        end else if (w_dec.ctrl) begin
            n_s1_rd = (r_ctrl & ~CTRL_CLR_MASK) | CTRL_SET_MASK;
        end else if (w_dec.winx) begin
            n_s1_rd = r_winx;
        end else if (w_dec.status) begin
            n_s1_rd = STATUS_READ;
        end else if (w_dec.aux_lo) begin
            n_s1_rd = r_aux_lo;
        end else if (w_dec.aux_hi) begin
            n_s1_rd = r_aux_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl   <= '0;
            r_winx   <= '0;
            r_aux_lo <= '0;
            r_aux_hi <= '0;
            r_ptr    <= '0;
            r_idx    <= '0;
            for (int k = 0; k < NUM_SETTINGS; k++) begin
                r_setting[k] <= (k == STATUS_SLOT) ? DATA_W'(1) : '0;
            end
        end else begin
            r_ptr <= n_ptr;
            r_idx <= n_idx;
            if (w_wr) begin
                if (w_dec.ctrl) begin
                    r_ctrl <= i_write_data;
                end
                if (w_dec.winx) begin
                    r_winx <= i_write_data;
                end
                if (w_dec.aux_lo) begin
                    r_aux_lo <= i_write_data;
                end
                if (w_dec.aux_hi) begin
                    r_aux_hi <= i_write_data;
                end
                if (w_dec.setting) begin
                    r_setting[w_dec.slot] <= i_write_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr && w_dec.ram) begin
            r_mem[r_idx] <= i_write_data;
        end
        if (w_rd && w_dec.ram) begin
            r_ram_q <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_rd  <= n_s1_rd;
            r_s1_bad <= n_s1_bad;
            r_s1_ram <= !i_command && w_dec.ram;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_rd  <= r_s1_ram ? r_ram_q : r_s1_rd;
            r_out_bad <= r_s1_bad;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_rd;
    assign o_bad_write = r_out_bad;

endmodule

@@ tb/tb_video_decoder_register_port_core.sv @@
`timescale 1ns / 100ps

module tb_video_decoder_register_port_core;
    import vdrp_pkg::*;

    typedef struct {
        logic              cmd;
        logic [OFF_W-1:0]  off;
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] rd;
        logic              bad;
    } t_access;

    logic              i_clk;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_ready;
    logic              i_command    = 1'b0;
    logic [OFF_W-1:0]  i_offset     = '0;
    logic [DATA_W-1:0] i_write_data = '0;
    logic              o_out_valid;
    logic              i_out_ready  = 1'b0;
    logic [DATA_W-1:0] o_read_data;
    logic              o_bad_write;

    video_decoder_register_port_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_offset     (i_offset),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_data  (o_read_data),
        .o_bad_write  (o_bad_write)
    );

    // register file shadow
    logic [DATA_W-1:0] ctrl_q;
    logic [DATA_W-1:0] winx_q;
    logic [DATA_W-1:0] aux_lo_q;
    logic [DATA_W-1:0] aux_hi_q;
    logic [DATA_W-1:0] settings_q [NUM_SETTINGS];
    logic [PTR_W-1:0]  ptr_q;
    logic [DATA_W-1:0] frame_mem [VDRP_RAM_DEPTH];
    bit                frame_written [VDRP_RAM_DEPTH];

    t_access pending_access_q [$];
    t_access expected_resp_q [$];
    t_access cur_access;

    int planned_count;
    int mismatch_count;
    int results_seen;
    int gap_cnt;
    bit gap_mode;
    int stall_cnt;
    int hold_cnt;
    bit hold_done;
    bit stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic void decode_access(input logic cmd, input logic [OFF_W-1:0] off,
                                          input logic [DATA_W-1:0] data,
                                          output logic [DATA_W-1:0] rd, output logic bad);
        int slot;
        int idx;
        slot = -1;
        for (int i = 0; i < NUM_SETTINGS; i++) begin
            if (SETTING_OFFS[i] == off) slot = i;
        end
        idx = int'(ptr_q) % VDRP_RAM_DEPTH;
        rd  = '0;
        bad = 1'b0;
        if (cmd) begin
            if (off == OFF_CTRL) begin
                ctrl_q = data;
            end else if (off == OFF_WINX) begin
                winx_q = data;
            end else if (off == OFF_PTR) begin
                ptr_q = {data, 2'b00};
            end else if (off == OFF_RAM) begin
                frame_mem[idx]     = data;
                frame_written[idx] = 1'b1;
                ptr_q              = ptr_q + 1'b1;
            end else if (off == OFF_AUX_LO) begin
                aux_lo_q = data;
            end else if (off == OFF_AUX_HI) begin
                aux_hi_q = data;
            end else if (slot >= 0) begin
                settings_q[slot] = data;
            end else begin
                bad = 1'b1;
            end
        end else begin
            if (off == OFF_CTRL) begin
                rd = (ctrl_q & ~CTRL_CLR_MASK) | CTRL_SET_MASK;
            end else if (off == OFF_WINX) begin
                rd = winx_q;
            end else if (off == OFF_STATUS) begin
                rd = STATUS_READ;
            end else if (off == OFF_RAM) begin
                rd    = frame_mem[idx];
                ptr_q = ptr_q + 1'b1;
            end else if (off == OFF_AUX_LO) begin
                rd = aux_lo_q;
            end else if (off == OFF_AUX_HI) begin
                rd = aux_hi_q;
            end
        end
    endfunction

    // turn a RAM read of an unwritten word into a write
    task automatic add_access(input logic cmd, input logic [OFF_W-1:0] off,
                              input logic [DATA_W-1:0] data);
        t_access a;
        a.cmd  = cmd;
        a.off  = off;
        a.data = data;
        if (!cmd && off == OFF_RAM && !frame_written[int'(ptr_q) % VDRP_RAM_DEPTH]) begin
            a.cmd = 1'b1;
        end
        decode_access(a.cmd, a.off, a.data, a.rd, a.bad);
        pending_access_q.push_back(a);
        planned_count++;
    endtask

    task automatic wait_idle();
        while (pending_access_q.size() != 0 || i_in_valid || expected_resp_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        logic    vld;
        t_access a;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            vld = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                expected_resp_q.push_back(cur_access);
                vld = 1'b0;
            end
            if (!vld) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                end else if (pending_access_q.size() > 0) begin
                    a            = pending_access_q.pop_front();
                    cur_access   = a;
                    i_command    <= a.cmd;
                    i_offset     <= a.off;
                    i_write_data <= a.data;
                    vld          = 1'b1;
                    if ($urandom_range(0, 39) == 0) gap_mode = !gap_mode;
                    gap_cnt = gap_mode ? $urandom_range(0, 15) : 0;
                end
            end
            i_in_valid <= vld;
        end
    end

    always @(posedge i_clk) begin
        logic    rdy;
        t_access e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            rdy = i_out_ready;
            if (o_out_valid && i_out_ready) begin
                if (expected_resp_q.size() == 0) begin
                    $error("unexpected item: read_data %h bad_write %b", o_read_data, o_bad_write);
                    mismatch_count++;
                end else begin
                    e = expected_resp_q.pop_front();
                    if (o_read_data !== e.rd) begin
                        $error("read_data: expected %h, actual %h", e.rd, o_read_data);
                        mismatch_count++;
                    end
                    if (o_bad_write !== e.bad) begin
                        $error("bad_write: expected %b, actual %b", e.bad, o_bad_write);
                        mismatch_count++;
                    end
                end
                results_seen++;
                if ($urandom_range(0, 29) == 0) stall_mode = !stall_mode;
                stall_cnt = stall_mode ? $urandom_range(0, 15) : 0;
                // hold off long enough to back up the input side
                if (!hold_done && results_seen == 300) begin
                    hold_done = 1'b1;
                    hold_cnt  = 250;
                end
                rdy = (stall_cnt == 0 && hold_cnt == 0);
            end else if (!rdy) begin
                if (hold_cnt > 0) hold_cnt--;
                else if (stall_cnt > 0) stall_cnt--;
                rdy = (hold_cnt == 0 && stall_cnt == 0);
            end
            i_out_ready <= rdy;
        end
    end

    initial begin
        int                n;
        int                nrd;
        int                r;
        logic [DATA_W-1:0] base;
        logic [OFF_W-1:0]  off;
        ctrl_q   = '0;
        winx_q   = '0;
        aux_lo_q = '0;
        aux_hi_q = '0;
        ptr_q    = '0;
        for (int i = 0; i < NUM_SETTINGS; i++) settings_q[i] = '0;
        settings_q[STATUS_SLOT] = 16'h0001;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_access(1'b0, OFF_CTRL, 16'hffff);
        add_access(1'b0, OFF_STATUS, 16'h0000);
        add_access(1'b1, OFF_CTRL, 16'hffff);
        add_access(1'b0, OFF_CTRL, 16'h0000);
        add_access(1'b1, OFF_WINX, 16'hffff);
        add_access(1'b0, OFF_WINX, 16'h0000);
        add_access(1'b1, OFF_AUX_LO, 16'ha5a5);
        add_access(1'b1, OFF_AUX_HI, 16'h5a5a);
        add_access(1'b0, OFF_AUX_LO, 16'h0000);
        add_access(1'b0, OFF_AUX_HI, 16'h0000);
        add_access(1'b1, OFF_STATUS, 16'h0000);
        add_access(1'b0, OFF_STATUS, 16'h0000);
        add_access(1'b1, SETTING_OFFS[NUM_SETTINGS-1], 16'hffff);
        add_access(1'b1, 20'h00001, 16'h1234);
        add_access(1'b1, 20'hfffff, 16'hffff);
        add_access(1'b0, 20'hfffff, 16'hffff);
        // pointer wrap across the top of the RAM
        add_access(1'b1, OFF_PTR, 16'hffff);
        repeat (5) add_access(1'b1, OFF_RAM, DATA_W'($urandom()));
        add_access(1'b1, OFF_PTR, 16'hffff);
        repeat (5) add_access(1'b0, OFF_RAM, DATA_W'($urandom()));
        wait_idle();

        for (int ph = 0; ph < 5; ph++) begin
            n = planned_count + 190;
            while (planned_count < n) begin
                if ($urandom_range(0, 9) < 5) begin
                    if ($urandom_range(0, 7) == 0) base = DATA_W'(16'hffff - $urandom_range(0, 2));
                    else base = DATA_W'($urandom());
                    r = $urandom_range(1, 8);
                    add_access(1'b1, OFF_PTR, base);
                    repeat (r) add_access(1'b1, OFF_RAM, DATA_W'($urandom()));
                    add_access(1'b1, OFF_PTR, base);
                    nrd = $urandom_range(1, r + 2);
                    repeat (nrd) begin
                        if ($urandom_range(0, 4) == 0) begin
                            add_access(1'($urandom_range(0, 1)), OFF_AUX_HI,
                                       DATA_W'($urandom()));
                        end
                        add_access(1'b0, OFF_RAM, DATA_W'($urandom()));
                    end
                end else begin
                    r = $urandom_range(0, 5);
                    if (r < 2) begin
                        r = $urandom_range(0, 6 + NUM_SETTINGS);
                        case (r)
                            0:       off = OFF_CTRL;
                            1:       off = OFF_WINX;
                            2:       off = OFF_PTR;
                            3:       off = OFF_STATUS;
                            4:       off = OFF_RAM;
                            5:       off = OFF_AUX_LO;
                            6:       off = OFF_AUX_HI;
                            default: off = SETTING_OFFS[r - 7];
                        endcase
                    end else if (r == 2) begin
                        off = {($urandom_range(0, 1) ? OFF_AUX_LO[OFF_W-1:8] : 12'h000),
                               8'($urandom_range(0, 255))};
                    end else begin
                        off = OFF_W'($urandom_range(0, 20'hfffff));
                    end
                    add_access(1'($urandom_range(0, 1)), off, DATA_W'($urandom()));
                end
            end
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_resp_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/vdrp_pkg.sv
src/vdrp_decode.sv
src/video_decoder_register_port_core.sv
tb/tb_video_decoder_register_port_core.sv
